// File: hdl/efp_pkg.sv
package efp_pkg;

  // Framing symbols
  localparam logic [7:0] SYM_STX = 8'hEB;
  localparam logic [7:0] SYM_ETX = 8'h30;
  localparam logic [7:0] SYM_ESC = 8'hEF;

  // Payload store geometry and field widths
  localparam int STORE_DEPTH     = 64;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int LEN_W           = 7;
  localparam int STEP_W          = 3;
  localparam int MAX_PAYLOAD_DEF = 64;

  // Parser steps (also reported as error_step)
  localparam logic [STEP_W-1:0] STEP_HUNT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CMD  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LEN  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DATA = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SUM  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ETX  = 3'd5;

  // Parser to emitter: start a payload run
  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  len;
    logic [7:0]        cmd;
    logic [STEP_W-1:0] err;
  } emit_req_t;

endpackage

// File: hdl/efp_ram.sv
module efp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/efp_parser.sv
module efp_parser #(
  parameter int MAX_PAYLOAD = efp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [7:0]                    in_byte,
  output logic                          wr_en,
  output logic [efp_pkg::STORE_AW-1:0]  wr_addr,
  output logic [7:0]                    wr_data,
  output efp_pkg::emit_req_t            req
);

  import efp_pkg::*;

  logic [STEP_W-1:0] step, step_next, cur;
  logic              esc, esc_next;
  logic              len_phase, len_phase_next;
  logic [LEN_W-1:0]  count, count_next, count_inc;
  logic [7:0]        cmd, cmd_next;
  logic [7:0]        len_lo, len_lo_next;
  logic [LEN_W-1:0]  len7, len7_next;
  logic [7:0]        sum, sum_next;
  logic [STEP_W-1:0] last_err, last_err_next;
  logic [7:0]        d;
  logic [15:0]       len_full;
  logic              parse;

  assign count_inc = count + 1'b1;

  always_comb begin
    step_next      = step;
    esc_next       = esc;
    len_phase_next = len_phase;
    count_next     = count;
    cmd_next       = cmd;
    len_lo_next    = len_lo;
    len7_next      = len7;
    sum_next       = sum;
    last_err_next  = last_err;
    d              = in_byte;
    len_full       = {in_byte, len_lo};
    parse          = 1'b0;
    cur            = step;
    wr_en          = 1'b0;
    req.start      = 1'b0;
    req.len        = len7;
    req.cmd        = cmd;
    req.err        = last_err;

    if (accept) begin
      // unescape; a raw STX always resyncs and is never escaped
      if (in_byte == SYM_STX) begin
        last_err_next = step;
        cur           = STEP_HUNT;
        parse         = 1'b1;
      end else if (in_byte == SYM_ESC && !esc) begin
        esc_next = 1'b1;
      end else if (esc) begin
        d        = in_byte + SYM_ESC;
        esc_next = 1'b0;
        parse    = 1'b1;
      end else begin
        parse = 1'b1;
      end

      len_full = {d, len_lo};

      if (parse) begin
        case (cur)
          STEP_HUNT: begin
            step_next = (d == SYM_STX) ? STEP_CMD : STEP_HUNT;
          end
          STEP_CMD: begin
            cmd_next       = d;
            sum_next       = SYM_STX + d;
            len_phase_next = 1'b0;
            count_next     = '0;
            step_next      = STEP_LEN;
          end
          STEP_LEN: begin
            sum_next = sum + d;
            if (!len_phase) begin
              len_lo_next    = d;
              len_phase_next = 1'b1;
            end else begin
              len_phase_next = 1'b0;
              count_next     = '0;
              len7_next      = len_full[LEN_W-1:0];
              if (len_full > 16'(MAX_PAYLOAD)) begin
                last_err_next = STEP_LEN;
                step_next     = STEP_HUNT;
              end else if (len_full == 16'd0) begin
                step_next = STEP_SUM;
              end else begin
                step_next = STEP_DATA;
              end
            end
          end
          STEP_DATA: begin
            wr_en      = 1'b1;
            sum_next   = sum + d;
            count_next = count_inc;
            if (count_inc >= len7) begin
              step_next = STEP_SUM;
            end
          end
          STEP_SUM: begin
            if (sum == d) begin
              step_next = STEP_ETX;
            end else begin
              last_err_next = STEP_SUM;
              step_next     = STEP_HUNT;
            end
          end
          STEP_ETX: begin
            // stays here: every later ETX replays the packet
            req.start = (d == SYM_ETX);
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign wr_addr  = count[STORE_AW-1:0];
  assign wr_data  = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_HUNT;
      esc       <= 1'b0;
      len_phase <= 1'b0;
      count     <= '0;
      cmd       <= '0;
      len_lo    <= '0;
      len7      <= '0;
      sum       <= '0;
      last_err  <= STEP_HUNT;
    end else begin
      step      <= step_next;
      esc       <= esc_next;
      len_phase <= len_phase_next;
      count     <= count_next;
      cmd       <= cmd_next;
      len_lo    <= len_lo_next;
      len7      <= len7_next;
      sum       <= sum_next;
      last_err  <= last_err_next;
    end
  end

`ifndef SYNTHESIS
  a_wr_only_in_data: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (step == STEP_DATA && accept))
    else $error("payload write outside data step");
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_DATA) |-> (count < len7))
    else $error("byte count ran past length");
  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_ETX || step == STEP_DATA) |-> (len7 <= LEN_W'(MAX_PAYLOAD)))
    else $error("stored length above maximum");
`endif

endmodule

// File: hdl/efp_emitter.sv
module efp_emitter (
  input  logic                          clk,
  input  logic                          rst,
  input  efp_pkg::emit_req_t            req,
  output logic                          rd_en,
  output logic [efp_pkg::STORE_AW-1:0]  rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          busy_any,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    command,
  output logic [efp_pkg::LEN_W-1:0]     payload_length,
  output logic [7:0]                    data_byte,
  output logic [efp_pkg::STORE_AW-1:0]  data_index,
  output logic                          has_data,
  output logic                          last,
  output logic [efp_pkg::STEP_W-1:0]    error_step
);

  import efp_pkg::*;

  logic                busy;
  logic [LEN_W-1:0]    k;
  logic [LEN_W-1:0]    len;
  logic [7:0]          cmd;
  logic [STEP_W-1:0]   err;
  // pend: RAM read data (or an empty-packet marker) waiting for the output reg
  logic                pend;
  logic                pend_empty;
  logic                pend_last;
  logic [STORE_AW-1:0] pend_idx;
  logic                move;
  logic [LEN_W-1:0]    k_inc;

  assign move     = pend && (!out_valid || !out_stall);
  assign rd_en    = busy && (!pend || move);
  assign rd_addr  = k[STORE_AW-1:0];
  assign k_inc    = k + 1'b1;
  assign busy_any = busy || pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.start) begin
        cmd <= req.cmd;
        len <= req.len;
        err <= req.err;
        k   <= '0;
        if (req.len == '0) begin
          pend       <= 1'b1;
          pend_empty <= 1'b1;
          pend_last  <= 1'b1;
          pend_idx   <= '0;
        end else begin
          busy <= 1'b1;
        end
      end else if (rd_en) begin
        pend       <= 1'b1;
        pend_empty <= 1'b0;
        pend_last  <= (k_inc == len);
        pend_idx   <= k[STORE_AW-1:0];
        k          <= k_inc;
        if (k_inc == len) begin
          busy <= 1'b0;
        end
      end else if (move) begin
        pend <= 1'b0;
      end

      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (move) begin
      command        <= cmd;
      payload_length <= pend_empty ? '0 : len;
      data_byte      <= pend_empty ? 8'h00 : rd_data;
      data_index     <= pend_idx;
      has_data       <= !pend_empty;
      last           <= pend_last;
      error_step     <= err;
    end
  end

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (!busy && !pend))
    else $error("run started while previous run active");
  a_more_after_nonlast: assert property (@(posedge clk) disable iff (rst)
    (move && !pend_last) |-> busy)
    else $error("run ended before last word");
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_data) |-> (last && data_byte == 8'h00 && data_index == '0))
    else $error("empty-packet word malformed");
`endif

endmodule

// File: hdl/escaped_frame_parser_core.sv
// Receive-side parser for byte-stuffed frames (STX 0xEB, command, 16-bit
// little-endian length, payload, 8-bit additive checksum, ETX 0x30). One raw
// link byte is taken per input word; 0xEF escapes the next byte (decoded by
// adding 0xEF). Payload bytes go into a 64-entry single-write, single-read
// RAM. Every ETX seen after a good checksum replays the stored packet as one
// output word per payload byte (a single word with has_data low for an empty
// payload); the parser stays in the ETX step, so repeated ETX bytes replay it.
// Rate: while no packet is being played out an input word is taken every
// cycle. An ETX that triggers playback holds in_stall high until every RAM read
// of the run has been handed to the output register; the one RAM read port
// gives one payload byte per cycle while out_stall is low.
// The output register lets the next input word in while the final output
// word still waits. error_step reports the parser step at which the most
// recent resync happened (raw STX, oversize length, bad checksum).
module escaped_frame_parser_core #(
  parameter int MAX_PAYLOAD = efp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    command,
  output logic [efp_pkg::LEN_W-1:0]     payload_length,
  output logic [7:0]                    data_byte,
  output logic [efp_pkg::STORE_AW-1:0]  data_index,
  output logic                          has_data,
  output logic                          last,
  output logic [efp_pkg::STEP_W-1:0]    error_step
);

  import efp_pkg::*;

  logic                accept;
  logic                busy_any;
  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;
  emit_req_t           req;

  // input held off while a payload run is being read out of the store
  assign in_stall = busy_any;
  assign accept   = in_valid && !in_stall;

  efp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .in_byte(in_byte),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .req    (req)
  );

  // payload store: written during the data step, read only during playback
  efp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  efp_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy_any      (busy_any),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .payload_length(payload_length),
    .data_byte     (data_byte),
    .data_index    (data_index),
    .has_data      (has_data),
    .last          (last),
    .error_step    (error_step)
  );

endmodule

// File: bench/escaped_frame_parser_core_tb.sv
`timescale 1ns / 1ps

module escaped_frame_parser_core_tb;
  import efp_pkg::*;

  localparam int MAX_LEN        = MAX_PAYLOAD_DEF;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 100;   // longer than the longest playback, plus slack

  // Frame flavors for the random traffic generator
  localparam int FR_GOOD    = 0;
  localparam int FR_BAD_SUM = 1;
  localparam int FR_CUT     = 2;

  // One output word as the parser should present it
  typedef struct packed {
    logic [7:0]          command;
    logic [LEN_W-1:0]    plen;
    logic [7:0]          data;
    logic [STORE_AW-1:0] idx;
    logic                has_data;
    logic                last;
    logic [STEP_W-1:0]   err;
  } replay_word_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [7:0]          in_byte   = 8'h00;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [7:0]          command;
  logic [LEN_W-1:0]    payload_length;
  logic [7:0]          data_byte;
  logic [STORE_AW-1:0] data_index;
  logic                has_data;
  logic                last;
  logic [STEP_W-1:0]   error_step;

  escaped_frame_parser_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command        (command),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .data_index     (data_index),
    .has_data       (has_data),
    .last           (last),
    .error_step     (error_step)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Parser shadow state: mirrors what the block should hold after each
  // accepted input word.
  // ---------------------------------------------------------------------
  logic [STEP_W-1:0] p_step;
  logic              esc_pend;
  logic              len_hi;     // next length byte is the high one
  logic [LEN_W-1:0]  cnt;
  logic [7:0]        cmd_q;
  logic [15:0]       len_q;
  logic [7:0]        sum_q;
  logic [7:0]        store [STORE_DEPTH];
  logic [STEP_W-1:0] err_q;

  replay_word_t replay_q [$];   // words the block still owes us, oldest first

  int errors       = 0;
  int words_in     = 0;
  int words_out    = 0;
  int words_sent   = 0;
  int replays      = 0;
  int resyncs      = 0;
  int stuck_cycles = 0;

  // Idle knobs, percent per cycle
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // Any resync records the step it interrupted
  function automatic void resync_parser();
    err_q  = p_step;
    p_step = STEP_HUNT;
    resyncs++;
  endfunction

  // Advance the shadow parser by one raw link byte; queue any replayed words.
  function automatic void parse_byte(input logic [7:0] raw);
    logic [7:0]   d;
    replay_word_t w;
    if (raw == SYM_STX) begin
      // raw STX is never escaped and always restarts; escape flag survives it
      d = raw;
      resync_parser();
    end else if (raw == SYM_ESC && !esc_pend) begin
      esc_pend = 1'b1;
      return;
    end else if (esc_pend) begin
      d        = raw + SYM_ESC;  // ESC ESC lands here too and decodes to 0xDE
      esc_pend = 1'b0;
    end else begin
      d = raw;
    end

    case (p_step)
      STEP_HUNT: begin
        // decoded STX (escaped) also opens a frame
        if (d == SYM_STX) p_step = STEP_CMD;
      end
      STEP_CMD: begin
        cmd_q  = d;
        sum_q  = SYM_STX + d;
        len_hi = 1'b0;
        cnt    = '0;
        p_step = STEP_LEN;
      end
      STEP_LEN: begin
        sum_q = sum_q + d;
        if (!len_hi) begin
          len_q  = {8'h00, d};
          len_hi = 1'b1;
        end else begin
          len_q  = {d, len_q[7:0]};   // high byte goes on top
          len_hi = 1'b0;
          cnt    = '0;
          if (len_q > MAX_LEN) resync_parser();
          else if (len_q == 0) p_step = STEP_SUM;
          else p_step = STEP_DATA;
        end
      end
      STEP_DATA: begin
        store[cnt[STORE_AW-1:0]] = d;
        sum_q = sum_q + d;
        cnt   = cnt + 1'b1;
        if (cnt >= len_q) p_step = STEP_SUM;
      end
      STEP_SUM: begin
        if (sum_q == d) p_step = STEP_ETX;
        else resync_parser();
      end
      STEP_ETX: begin
        // parser parks here: every ETX replays the stored packet
        if (d == SYM_ETX) begin
          replays++;
          if (len_q == 0) begin
            w = '{command: cmd_q, plen: '0, data: '0, idx: '0,
                  has_data: 1'b0, last: 1'b1, err: err_q};
            replay_q.push_back(w);
          end else begin
            for (int k = 0; k < len_q; k++) begin
              w.command  = cmd_q;
              w.plen     = len_q[LEN_W-1:0];
              w.data     = store[k];
              w.idx      = STORE_AW'(k);
              w.has_data = 1'b1;
              w.last     = (k == len_q - 1);
              w.err      = err_q;
              replay_q.push_back(w);
            end
          end
        end
      end
      default: ;  // unreachable steps ignore the byte
    endcase
  endfunction

  task automatic cmp_field(input string name, input logic [15:0] exp_v,
                           input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, name, exp_v, act_v);
    end
  endtask

  // Compare the word on the output ports against the oldest expectation
  task automatic check_word();
    replay_word_t e;
    if (replay_q.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected output word cmd=0x%0h idx=%0d data=0x%0h",
               $time, command, data_index, data_byte);
      return;
    end
    e = replay_q.pop_front();
    cmp_field("command",        e.command,  command);
    cmp_field("payload_length", e.plen,     payload_length);
    cmp_field("data_byte",      e.data,     data_byte);
    cmp_field("data_index",     e.idx,      data_index);
    cmp_field("has_data",       e.has_data, has_data);
    cmp_field("last",           e.last,     last);
    cmp_field("error_step",     e.err,      error_step);
  endtask

  // Monitor: both handshakes sampled at the rising edge, plus the watchdog.
  // Input side goes first so a word is predicted before anything it causes.
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        parse_byte(in_byte);
        words_in++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        check_word();
        words_out++;
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: watchdog expired, %0d words still owed",
                 $time, replay_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Present one raw byte, with random idle cycles ahead of it, and hold it
  // until taken. Entered and left at a falling edge.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Byte-stuff one decoded value. STX and ESC must be escaped; others are
  // escaped now and then, except the one value whose escaped form is a raw STX.
  task automatic send_stuffed(input logic [7:0] v);
    if (v == SYM_STX || v == SYM_ESC ||
        (v != 8'(SYM_STX + SYM_ESC) && $urandom_range(9) == 0)) begin
      send_word(SYM_ESC);
      send_word(v - SYM_ESC);
    end else begin
      send_word(v);
    end
  endtask

  // Payload content, leaning on the framing symbols and their neighbors
  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(15))
      0:       return SYM_STX;
      1:       return SYM_ESC;
      2:       return SYM_ETX;
      3:       return 8'(SYM_STX + SYM_ESC);
      4:       return 8'(SYM_ESC + SYM_ESC);
      5:       return 8'h00;
      6:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Full frame: raw STX, stuffed header/payload/checksum, then n_etx ETX bytes.
  // Oversize lengths stop after the header since the parser has already bailed.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input int flavor, input int n_etx);
    logic [7:0] body [$];
    logic [7:0] sum;
    int         keep;
    body = '{cmd, len[7:0], len[15:8]};
    if (len <= MAX_LEN) begin
      repeat (len) body.push_back(pick_data_byte());
      sum = SYM_STX;
      foreach (body[i]) sum = sum + body[i];
      if (flavor == FR_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
      body.push_back(sum);
    end
    keep = (flavor == FR_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
    send_word(SYM_STX);
    for (int i = 0; i < keep; i++) send_stuffed(body[i]);
    if (flavor != FR_CUT && len <= MAX_LEN) begin
      repeat (n_etx) begin
        // stray byte parked in the ETX step (neither STX nor ESC) is ignored unless it equals ETX
        if ($urandom_range(3) == 0) send_word(8'($urandom_range(0, 8'hEA)));
        send_word(SYM_ETX);
      end
    end
  endtask

  task automatic send_random_frame();
    int          pick;
    logic [7:0]  cmd;
    logic [15:0] len;
    pick = $urandom_range(99);
    cmd  = pick_data_byte();
    len  = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    if ($urandom_range(7) == 0) len = 16'($urandom_range(7, 20));
    if (pick < 65) begin
      send_frame(cmd, len, FR_GOOD, $urandom_range(5) == 0 ? 2 : 1);
    end else if (pick < 77) begin
      send_frame(cmd, len, FR_BAD_SUM, 1);
    end else if (pick < 85) begin
      len = $urandom_range(1) ? 16'($urandom_range(MAX_LEN + 1, 96))
                              : 16'($urandom_range(MAX_LEN + 1, 16'hFFFF));
      send_frame(cmd, len, FR_GOOD, 0);
    end else if (pick < 93) begin
      send_frame(cmd, len, FR_CUT, 0);
    end else begin
      // line noise, may leave an escape pending for the next frame
      repeat ($urandom_range(1, 4)) send_word(pick_data_byte());
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Zero-length payload, all-ones command, repeated ETX with noise between
  task automatic test_empty_packet();
    logic [7:0] seq [8];
    seq = '{SYM_STX, 8'hFF, 8'h00, 8'h00, 8'hEA, SYM_ETX, 8'h55, SYM_ETX};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  // Raw STX from the ETX step, then a wrong checksum
  task automatic test_bad_checksum();
    logic [7:0] seq [5];
    seq = '{SYM_STX, 8'h01, 8'h00, 8'h00, 8'h00};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  // Escaped STX opens the frame, ESC ESC gives the command, escaped payload
  task automatic test_escapes();
    logic [7:0] seq [10];
    seq = '{SYM_ESC, 8'hFC, SYM_ESC, SYM_ESC, 8'h01, 8'h00,
            SYM_ESC, 8'h00, 8'hB9, SYM_ETX};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  // Length 65 (low byte) and 256 (high byte, checks byte order)
  task automatic test_oversize_length();
    logic [7:0] seq [8];
    seq = '{SYM_STX, 8'h00, 8'h41, 8'h00, SYM_STX, 8'h00, 8'h00, 8'h01};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  // Largest payload, replayed twice
  task automatic test_max_payload();
    send_frame(8'hA5, 16'(MAX_LEN), FR_GOOD, 2);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_p,
                                     input int n_words);
    int start;
    sender_idle_pct = idle_pct;
    stall_pct       = stall_p;
    start           = words_sent;
    while (words_sent - start < n_words) send_random_frame();
  endtask

  initial begin
    p_step   = STEP_HUNT;
    esc_pend = 1'b0;
    len_hi   = 1'b0;
    cnt      = '0;
    cmd_q    = '0;
    len_q    = '0;
    sum_q    = '0;
    err_q    = STEP_HUNT;

    // reset held from the start, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_packet();
    test_bad_checksum();
    test_escapes();
    test_oversize_length();

    test_random_traffic(0, 0, 4);     // back to back
    test_random_traffic(68, 0, 4);    // sparse sender
    test_random_traffic(0, 68, 4);    // heavy back-pressure
    test_max_payload();               // still under back-pressure
    test_random_traffic(6, 6, 4);     // light idling on both sides

    in_valid <= 1'b0;
    while (replay_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d link bytes, checked %0d output words from %0d replays",
             words_in, words_out, replays);
    $display("Covered escapes, resyncs (%0d), oversize lengths, bad checksums, %0d-byte payload",
             resyncs, MAX_LEN);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
